// ===== rtl/core/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int DEPTH   = 256;
    localparam int IDX_W   = 8;
    localparam int LEN_W   = 9;
    localparam int TRK_W   = 16;
    localparam int POS_W   = 9;
    localparam int STEP_W  = 16;
    localparam int REQ_W   = 4;
    localparam int STS_W   = 2;
    localparam int RPT_W   = 2;
    localparam int GEN_W   = 16;
    localparam int RNG_W   = 32;

    localparam logic [RNG_W-1:0] LCG_MUL   = 32'd1664525;
    localparam logic [RNG_W-1:0] LCG_ADD   = 32'd1013904223;
    localparam logic [RNG_W-1:0] RNG_SEED  = 32'h43505f36;
    localparam logic [GEN_W-1:0] GEN_RESET = 16'd1;

    localparam logic [STS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [RPT_W-1:0] RPT_NONE = 2'd0;
    localparam logic [RPT_W-1:0] RPT_ALL  = 2'd1;
    localparam logic [RPT_W-1:0] RPT_ONE  = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 4'd0,
        REQ_REMOVE   = 4'd1,
        REQ_NEXT     = 4'd2,
        REQ_PEEK     = 4'd3,
        REQ_CHECK    = 4'd4,
        REQ_START    = 4'd5,
        REQ_SHUF_ON  = 4'd6,
        REQ_SHUF_OFF = 4'd7,
        REQ_CLEAR    = 4'd8,
        REQ_READ     = 4'd9
    } req_t;

    typedef enum logic [5:0] {
        OP_IDLE, OP_LOAD, OP_FAIL, OP_FULL,
        OP_INS_SET, OP_UP_RD, OP_UP_WR, OP_INS_FIN,
        OP_RM_SET, OP_DN_RD, OP_DN_WR, OP_RM_FIN,
        OP_K_POS, OP_K_CUR, OP_K_TGT, OP_WRAP_GO, OP_WRAP_FIN,
        OP_SET_IDX, OP_SET_START, OP_PK_RD, OP_PK_CAP,
        OP_SHUF_EMPTY, OP_CUR_RD, OP_CUR_CAP, OP_CP_RD, OP_CP_WR,
        OP_FY_SET, OP_FY_RNG, OP_FY_DIV, OP_PICK,
        OP_SW_RD1, OP_SW_RD2, OP_SW_WR1, OP_SW_WR2,
        OP_RF_SET, OP_RF_RD, OP_RF_CMP, OP_SHUF_FIN,
        OP_CLEAR, OP_WAIT, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic empty;
        logic full;
        logic in_range;
        logic rpt_all;
        logic hold;
        logic tgt_in;
        logic shuf;
        logic ptr_gt_r;
        logic dn_more;
        logic copy_done;
        logic ptr_zero;
        logic match;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_in_if.sv =====
`default_nettype none

interface spq_in_if;
    logic                            valid;
    logic                            ready;
    logic [spq_pkg::REQ_W-1:0]       req_type;
    logic [spq_pkg::TRK_W-1:0]       track_id;
    logic [spq_pkg::POS_W-1:0]       position;
    logic                            to_front;
    logic signed [spq_pkg::STEP_W-1:0] steps;
    logic [spq_pkg::IDX_W-1:0]       target_index;

    modport source (output valid, req_type, track_id, position, to_front, steps,
                    target_index, input ready);
    modport sink (input valid, req_type, track_id, position, to_front, steps,
                  target_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spq_out_if.sv =====
`default_nettype none

interface spq_out_if;
    logic                      valid;
    logic                      ready;
    logic [spq_pkg::STS_W-1:0] status;
    logic [spq_pkg::IDX_W-1:0] result_index;
    logic [spq_pkg::TRK_W-1:0] track_out;
    logic [spq_pkg::LEN_W-1:0] entry_count;
    logic [spq_pkg::IDX_W-1:0] current_index;
    logic                      shuffled;
    logic                      started;
    logic [spq_pkg::GEN_W-1:0] generation;

    modport source (output valid, status, result_index, track_out, entry_count,
                    current_index, shuffled, started, generation, input ready);
    modport sink (input valid, status, result_index, track_out, entry_count,
                  current_index, shuffled, started, generation, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spq_div.sv =====
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle.
module spq_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [spq_pkg::RNG_W-1:0] dividend,
    input  wire logic [spq_pkg::LEN_W-1:0] divisor,
    output logic                           done,
    output logic [spq_pkg::LEN_W-1:0]      rem
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [4:0]                cnt_reg;
    logic [spq_pkg::RNG_W-1:0] dvd_reg;
    logic [spq_pkg::LEN_W-1:0] dvs_reg;
    logic [spq_pkg::LEN_W-1:0] rem_reg;
    logic [spq_pkg::LEN_W:0]   trial;
    logic [spq_pkg::LEN_W:0]   rem_next;

    assign trial    = {rem_reg, dvd_reg[spq_pkg::RNG_W-1]};
    assign rem_next = (trial >= {1'b0, dvs_reg}) ? (trial - {1'b0, dvs_reg}) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[spq_pkg::RNG_W-2:0], 1'b0};
            rem_reg <= rem_next[spq_pkg::LEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("remainder unit restarted while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/spq_dp.sv =====
`default_nettype none

module spq_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire spq_pkg::cmd_t              cmd,
    output spq_pkg::sts_t                   sts,
    input  wire logic [spq_pkg::REQ_W-1:0]  in_req,
    input  wire logic [spq_pkg::TRK_W-1:0]  in_id,
    input  wire logic [spq_pkg::POS_W-1:0]  in_pos,
    input  wire logic                       in_front,
    input  wire logic [spq_pkg::STEP_W-1:0] in_steps,
    input  wire logic [spq_pkg::IDX_W-1:0]  in_tgt,
    input  wire logic                       cfg_we,
    input  wire logic [spq_pkg::RPT_W-1:0]  cfg_wdata,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [spq_pkg::STS_W-1:0]       out_status,
    output logic [spq_pkg::IDX_W-1:0]       out_rindex,
    output logic [spq_pkg::TRK_W-1:0]       out_track,
    output logic [spq_pkg::LEN_W-1:0]       out_count,
    output logic [spq_pkg::IDX_W-1:0]       out_cur,
    output logic                            out_shuf,
    output logic                            out_started,
    output logic [spq_pkg::GEN_W-1:0]       out_gen,
    output logic                            div_start,
    output logic [spq_pkg::RNG_W-1:0]       div_dividend,
    output logic [spq_pkg::LEN_W-1:0]       div_divisor,
    input  wire logic                       div_done,
    input  wire logic [spq_pkg::LEN_W-1:0]  div_rem
);

    // queue state
    logic [spq_pkg::LEN_W-1:0]  len_reg;
    logic [spq_pkg::IDX_W-1:0]  idx_reg;
    logic                       started_reg;
    logic                       shuf_reg;
    logic [spq_pkg::RNG_W-1:0]  rng_reg;
    logic [spq_pkg::GEN_W-1:0]  gen_reg;
    logic [spq_pkg::RPT_W-1:0]  rpt_reg;
    logic                       out_valid_reg;
    logic [spq_pkg::LEN_W-1:0]  ptr_reg;

    // latched request
    logic [spq_pkg::REQ_W-1:0]  req_reg;
    logic [spq_pkg::TRK_W-1:0]  id_reg;
    logic [spq_pkg::POS_W-1:0]  posn_reg;
    logic                       front_reg;
    logic [spq_pkg::STEP_W-1:0] steps_reg;
    logic [spq_pkg::IDX_W-1:0]  tgt_reg;

    // work registers
    logic [spq_pkg::STS_W-1:0]  status_reg;
    logic [spq_pkg::IDX_W-1:0]  rindex_reg;
    logic [spq_pkg::TRK_W-1:0]  track_reg;
    logic [spq_pkg::TRK_W-1:0]  cur_id_reg;
    logic [spq_pkg::TRK_W-1:0]  tmp_reg;
    logic [spq_pkg::IDX_W-1:0]  pick_reg;

    // result word
    logic [spq_pkg::STS_W-1:0]  o_status_reg;
    logic [spq_pkg::IDX_W-1:0]  o_rindex_reg;
    logic [spq_pkg::TRK_W-1:0]  o_track_reg;
    logic [spq_pkg::LEN_W-1:0]  o_count_reg;
    logic [spq_pkg::IDX_W-1:0]  o_cur_reg;
    logic                       o_shuf_reg;
    logic                       o_started_reg;
    logic [spq_pkg::GEN_W-1:0]  o_gen_reg;

    // working and saved order
    logic [spq_pkg::TRK_W-1:0]  wmem [spq_pkg::DEPTH];
    logic [spq_pkg::TRK_W-1:0]  smem [spq_pkg::DEPTH];
    logic [spq_pkg::TRK_W-1:0]  w_rdata;
    logic [spq_pkg::TRK_W-1:0]  s_rdata;
    logic [spq_pkg::IDX_W-1:0]  raddr;
    logic [spq_pkg::IDX_W-1:0]  waddr;
    logic                       w_we;
    logic                       s_we;
    logic [spq_pkg::TRK_W-1:0]  w_wd;
    logic [spq_pkg::TRK_W-1:0]  s_wd;

    logic signed [16:0]         pos_s;
    logic [16:0]                pos_u;
    logic [16:0]                pos_mag;
    logic                       in_range;
    logic [spq_pkg::LEN_W-1:0]  wrap_k;
    logic [spq_pkg::LEN_W-1:0]  ins_at;
    logic [spq_pkg::LEN_W-1:0]  len_dec;
    logic                       on;
    logic                       match;

    spq_pkg::op_t op;
    assign op = cmd.op;

    // current + steps, signed
    assign pos_s   = $signed({8'd0, idx_reg}) + $signed({steps_reg[15], steps_reg});
    assign pos_u   = pos_s;
    assign pos_mag = pos_s[16] ? (~pos_u + 17'd1) : pos_u;
    assign in_range = !pos_s[16] && (pos_u[15:0] < {7'd0, len_reg});
    // truncating remainder, then folded up for negative offsets
    assign wrap_k  = (pos_s[16] && (div_rem != '0)) ? (len_reg - div_rem) : div_rem;
    assign ins_at  = front_reg ? '0 : ((posn_reg <= len_reg) ? posn_reg : len_reg);
    assign len_dec = len_reg - 9'd1;
    assign on      = (req_reg == spq_pkg::REQ_SHUF_ON);
    assign match   = (w_rdata == cur_id_reg);

    assign sts.req       = req_reg;
    assign sts.empty     = (len_reg == '0);
    assign sts.full      = (len_reg >= spq_pkg::LEN_W'(spq_pkg::DEPTH));
    assign sts.in_range  = in_range;
    assign sts.rpt_all   = (rpt_reg == spq_pkg::RPT_ALL);
    assign sts.hold      = (rpt_reg == spq_pkg::RPT_ONE) && (steps_reg != '0);
    assign sts.tgt_in    = ({1'b0, tgt_reg} < len_reg);
    assign sts.shuf      = shuf_reg;
    assign sts.ptr_gt_r  = (ptr_reg > {1'b0, rindex_reg});
    assign sts.dn_more   = ((ptr_reg + 9'd1) < len_reg);
    assign sts.copy_done = (ptr_reg == len_reg);
    assign sts.ptr_zero  = (ptr_reg == '0);
    assign sts.match     = match;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign div_start    = (op == spq_pkg::OP_WRAP_GO) || (op == spq_pkg::OP_FY_DIV);
    assign div_dividend = (op == spq_pkg::OP_FY_DIV) ? rng_reg : {15'd0, pos_mag};
    assign div_divisor  = (op == spq_pkg::OP_FY_DIV) ? (ptr_reg + 9'd1) : len_reg;

    always_comb
    begin
        raddr = ptr_reg[spq_pkg::IDX_W-1:0];
        waddr = ptr_reg[spq_pkg::IDX_W-1:0];
        w_we  = 1'b0;
        s_we  = 1'b0;
        w_wd  = w_rdata;
        s_wd  = s_rdata;
        case (op)
            spq_pkg::OP_UP_RD:  raddr = spq_pkg::IDX_W'(ptr_reg - 9'd1);
            spq_pkg::OP_DN_RD:  raddr = spq_pkg::IDX_W'(ptr_reg + 9'd1);
            spq_pkg::OP_PK_RD:  raddr = rindex_reg;
            spq_pkg::OP_CUR_RD: raddr = idx_reg;
            spq_pkg::OP_SW_RD2: raddr = pick_reg;
            spq_pkg::OP_UP_WR,
            spq_pkg::OP_DN_WR:
            begin
                w_we = 1'b1;
                s_we = 1'b1;
            end
            spq_pkg::OP_INS_FIN:
            begin
                w_we  = 1'b1;
                s_we  = 1'b1;
                waddr = rindex_reg;
                w_wd  = id_reg;
                s_wd  = id_reg;
            end
            spq_pkg::OP_CP_WR:
            begin
                // shuffle on saves the working order, shuffle off restores it
                s_we = on;
                w_we = !on;
                s_wd = w_rdata;
                w_wd = s_rdata;
            end
            spq_pkg::OP_SW_WR1: w_we = 1'b1;
            spq_pkg::OP_SW_WR2:
            begin
                w_we  = 1'b1;
                waddr = pick_reg;
                w_wd  = tmp_reg;
            end
            default:
            begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[waddr] <= w_wd;
        end
        w_rdata <= wmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[waddr] <= s_wd;
        end
        s_rdata <= smem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            idx_reg       <= '0;
            started_reg   <= 1'b0;
            shuf_reg      <= 1'b0;
            rng_reg       <= spq_pkg::RNG_SEED;
            gen_reg       <= spq_pkg::GEN_RESET;
            rpt_reg       <= spq_pkg::RPT_NONE;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                rpt_reg <= cfg_wdata;
            end
            if (op == spq_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                spq_pkg::OP_INS_SET: ptr_reg <= len_reg;
                spq_pkg::OP_UP_WR:   ptr_reg <= ptr_reg - 9'd1;
                spq_pkg::OP_INS_FIN:
                begin
                    len_reg <= len_reg + 9'd1;
                    gen_reg <= gen_reg + 16'd1;
                end
                spq_pkg::OP_RM_SET:  ptr_reg <= {1'b0, pos_u[7:0]};
                spq_pkg::OP_DN_WR:   ptr_reg <= ptr_reg + 9'd1;
                spq_pkg::OP_RM_FIN:
                begin
                    len_reg <= len_dec;
                    gen_reg <= gen_reg + 16'd1;
                    if (len_dec == '0)
                    begin
                        idx_reg <= '0;
                    end
                    else if ({1'b0, idx_reg} >= len_dec)
                    begin
                        idx_reg <= spq_pkg::IDX_W'(len_dec - 9'd1);
                    end
                end
                spq_pkg::OP_SET_IDX: idx_reg <= rindex_reg;
                spq_pkg::OP_SET_START:
                begin
                    idx_reg     <= rindex_reg;
                    started_reg <= 1'b1;
                end
                spq_pkg::OP_SHUF_EMPTY: shuf_reg <= on;
                spq_pkg::OP_CUR_CAP:    ptr_reg  <= '0;
                spq_pkg::OP_CP_WR:      ptr_reg  <= ptr_reg + 9'd1;
                spq_pkg::OP_FY_SET:     ptr_reg  <= len_dec;
                spq_pkg::OP_FY_RNG:
                    rng_reg <= spq_pkg::RNG_W'(rng_reg * spq_pkg::LCG_MUL + spq_pkg::LCG_ADD);
                spq_pkg::OP_SW_WR2:     ptr_reg  <= ptr_reg - 9'd1;
                spq_pkg::OP_RF_SET:     ptr_reg  <= '0;
                spq_pkg::OP_RF_CMP:
                begin
                    ptr_reg <= ptr_reg + 9'd1;
                    if (match)
                    begin
                        idx_reg <= ptr_reg[spq_pkg::IDX_W-1:0];
                    end
                end
                spq_pkg::OP_SHUF_FIN:
                begin
                    shuf_reg <= on;
                    gen_reg  <= gen_reg + 16'd1;
                end
                spq_pkg::OP_CLEAR:
                begin
                    len_reg     <= '0;
                    idx_reg     <= '0;
                    started_reg <= 1'b0;
                    gen_reg     <= gen_reg + 16'd1;
                end
                default:
                begin
                    ptr_reg <= ptr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            spq_pkg::OP_LOAD:
            begin
                req_reg    <= in_req;
                id_reg     <= in_id;
                posn_reg   <= in_pos;
                front_reg  <= in_front;
                steps_reg  <= in_steps;
                tgt_reg    <= in_tgt;
                status_reg <= spq_pkg::ST_OK;
                rindex_reg <= '0;
                track_reg  <= '0;
            end
            spq_pkg::OP_FAIL:     status_reg <= spq_pkg::ST_INVALID;
            spq_pkg::OP_FULL:     status_reg <= spq_pkg::ST_FULL;
            spq_pkg::OP_INS_SET:  rindex_reg <= ins_at[spq_pkg::IDX_W-1:0];
            spq_pkg::OP_RM_SET,
            spq_pkg::OP_K_POS:    rindex_reg <= pos_u[spq_pkg::IDX_W-1:0];
            spq_pkg::OP_K_CUR:    rindex_reg <= idx_reg;
            spq_pkg::OP_K_TGT:    rindex_reg <= tgt_reg;
            spq_pkg::OP_WRAP_FIN: rindex_reg <= wrap_k[spq_pkg::IDX_W-1:0];
            spq_pkg::OP_PK_CAP:   track_reg  <= w_rdata;
            spq_pkg::OP_CUR_CAP:  cur_id_reg <= w_rdata;
            spq_pkg::OP_PICK:     pick_reg   <= div_rem[spq_pkg::IDX_W-1:0];
            spq_pkg::OP_SW_RD2:   tmp_reg    <= w_rdata;
            spq_pkg::OP_EMIT:
            begin
                o_status_reg  <= status_reg;
                o_rindex_reg  <= rindex_reg;
                o_track_reg   <= track_reg;
                o_count_reg   <= len_reg;
                o_cur_reg     <= idx_reg;
                o_shuf_reg    <= shuf_reg;
                o_started_reg <= started_reg;
                o_gen_reg     <= gen_reg;
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = o_status_reg;
    assign out_rindex  = o_rindex_reg;
    assign out_track   = o_track_reg;
    assign out_count   = o_count_reg;
    assign out_cur     = o_cur_reg;
    assign out_shuf    = o_shuf_reg;
    assign out_started = o_started_reg;
    assign out_gen     = o_gen_reg;

`ifndef SYNTHESIS
    a_idx_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> ({1'b0, idx_reg} < len_reg))
        else $error("current index past end of queue");
    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) |-> (idx_reg == '0))
        else $error("empty queue with nonzero index");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
`default_nettype none

module spq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire spq_pkg::sts_t sts,
    output spq_pkg::cmd_t      cmd
);

    typedef enum logic [24:0] {
        S_IDLE     = 25'b1 << 0,
        S_DEC      = 25'b1 << 1,
        S_UP_RD    = 25'b1 << 2,
        S_UP_WR    = 25'b1 << 3,
        S_DN_RD    = 25'b1 << 4,
        S_DN_WR    = 25'b1 << 5,
        S_WRAP     = 25'b1 << 6,
        S_APPLY    = 25'b1 << 7,
        S_PK_RD    = 25'b1 << 8,
        S_PK_CAP   = 25'b1 << 9,
        S_CUR_CAP  = 25'b1 << 10,
        S_CP_RD    = 25'b1 << 11,
        S_CP_WR    = 25'b1 << 12,
        S_FY_SET   = 25'b1 << 13,
        S_FY_RNG   = 25'b1 << 14,
        S_FY_DIV   = 25'b1 << 15,
        S_FY_WAIT  = 25'b1 << 16,
        S_SW_RD1   = 25'b1 << 17,
        S_SW_RD2   = 25'b1 << 18,
        S_SW_WR1   = 25'b1 << 19,
        S_SW_WR2   = 25'b1 << 20,
        S_RF_RD    = 25'b1 << 21,
        S_RF_CMP   = 25'b1 << 22,
        S_SHUF_FIN = 25'b1 << 23,
        S_DONE     = 25'b1 << 24
    } state_t;

    state_t state_reg;
    state_t state_next;
    spq_pkg::op_t op;
    logic is_next;

    assign is_next = (sts.req == spq_pkg::REQ_NEXT);
    assign cmd.op  = op;

    always_comb
    begin
        state_next = state_reg;
        op         = spq_pkg::OP_IDLE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = spq_pkg::OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                op         = spq_pkg::OP_FAIL;
                state_next = S_DONE;
                case (sts.req)
                    spq_pkg::REQ_INSERT:
                    begin
                        if (sts.full)
                        begin
                            op = spq_pkg::OP_FULL;
                        end
                        else
                        begin
                            op         = spq_pkg::OP_INS_SET;
                            state_next = S_UP_RD;
                        end
                    end
                    spq_pkg::REQ_REMOVE:
                    begin
                        if (sts.in_range)
                        begin
                            op         = spq_pkg::OP_RM_SET;
                            state_next = S_DN_RD;
                        end
                    end
                    spq_pkg::REQ_NEXT,
                    spq_pkg::REQ_PEEK:
                    begin
                        if (is_next && sts.hold)
                        begin
                            if (!sts.empty)
                            begin
                                op         = spq_pkg::OP_K_CUR;
                                state_next = S_APPLY;
                            end
                        end
                        else if (sts.empty)
                        begin
                            op = spq_pkg::OP_FAIL;
                        end
                        else if (sts.in_range)
                        begin
                            op         = spq_pkg::OP_K_POS;
                            state_next = is_next ? S_APPLY : S_PK_RD;
                        end
                        else if (sts.rpt_all)
                        begin
                            op         = spq_pkg::OP_WRAP_GO;
                            state_next = S_WRAP;
                        end
                    end
                    spq_pkg::REQ_CHECK:
                    begin
                        if (sts.in_range)
                        begin
                            op = spq_pkg::OP_K_POS;
                        end
                    end
                    spq_pkg::REQ_START:
                    begin
                        if (sts.tgt_in)
                        begin
                            op         = spq_pkg::OP_K_TGT;
                            state_next = S_APPLY;
                        end
                    end
                    spq_pkg::REQ_READ:
                    begin
                        if (sts.tgt_in)
                        begin
                            op         = spq_pkg::OP_K_TGT;
                            state_next = S_PK_RD;
                        end
                    end
                    spq_pkg::REQ_SHUF_ON,
                    spq_pkg::REQ_SHUF_OFF:
                    begin
                        if (sts.empty)
                        begin
                            op = spq_pkg::OP_SHUF_EMPTY;
                        end
                        else
                        begin
                            op         = spq_pkg::OP_CUR_RD;
                            state_next = S_CUR_CAP;
                        end
                    end
                    spq_pkg::REQ_CLEAR: op = spq_pkg::OP_CLEAR;
                    default:            op = spq_pkg::OP_FAIL;
                endcase
            end
            S_UP_RD:
            begin
                if (sts.ptr_gt_r)
                begin
                    op         = spq_pkg::OP_UP_RD;
                    state_next = S_UP_WR;
                end
                else
                begin
                    op         = spq_pkg::OP_INS_FIN;
                    state_next = S_DONE;
                end
            end
            S_UP_WR:
            begin
                op         = spq_pkg::OP_UP_WR;
                state_next = S_UP_RD;
            end
            S_DN_RD:
            begin
                if (sts.dn_more)
                begin
                    op         = spq_pkg::OP_DN_RD;
                    state_next = S_DN_WR;
                end
                else
                begin
                    op         = spq_pkg::OP_RM_FIN;
                    state_next = S_DONE;
                end
            end
            S_DN_WR:
            begin
                op         = spq_pkg::OP_DN_WR;
                state_next = S_DN_RD;
            end
            S_WRAP:
            begin
                op = spq_pkg::OP_WAIT;
                if (sts.div_done)
                begin
                    op         = spq_pkg::OP_WRAP_FIN;
                    state_next = is_next ? S_APPLY : S_PK_RD;
                end
            end
            S_APPLY:
            begin
                op = (sts.req == spq_pkg::REQ_START) ? spq_pkg::OP_SET_START
                                                      : spq_pkg::OP_SET_IDX;
                state_next = S_DONE;
            end
            S_PK_RD:
            begin
                op         = spq_pkg::OP_PK_RD;
                state_next = S_PK_CAP;
            end
            S_PK_CAP:
            begin
                op         = spq_pkg::OP_PK_CAP;
                state_next = S_DONE;
            end
            S_CUR_CAP:
            begin
                op = spq_pkg::OP_CUR_CAP;
                // reshuffle keeps the saved order
                if ((sts.req == spq_pkg::REQ_SHUF_ON) && sts.shuf)
                begin
                    state_next = S_FY_SET;
                end
                else
                begin
                    state_next = S_CP_RD;
                end
            end
            S_CP_RD:
            begin
                if (sts.copy_done)
                begin
                    if (sts.req == spq_pkg::REQ_SHUF_ON)
                    begin
                        op         = spq_pkg::OP_WAIT;
                        state_next = S_FY_SET;
                    end
                    else
                    begin
                        op         = spq_pkg::OP_RF_SET;
                        state_next = S_RF_RD;
                    end
                end
                else
                begin
                    op         = spq_pkg::OP_CP_RD;
                    state_next = S_CP_WR;
                end
            end
            S_CP_WR:
            begin
                op         = spq_pkg::OP_CP_WR;
                state_next = S_CP_RD;
            end
            S_FY_SET:
            begin
                op         = spq_pkg::OP_FY_SET;
                state_next = S_FY_RNG;
            end
            S_FY_RNG:
            begin
                if (sts.ptr_zero)
                begin
                    op         = spq_pkg::OP_RF_SET;
                    state_next = S_RF_RD;
                end
                else
                begin
                    op         = spq_pkg::OP_FY_RNG;
                    state_next = S_FY_DIV;
                end
            end
            S_FY_DIV:
            begin
                op         = spq_pkg::OP_FY_DIV;
                state_next = S_FY_WAIT;
            end
            S_FY_WAIT:
            begin
                op = spq_pkg::OP_WAIT;
                if (sts.div_done)
                begin
                    op         = spq_pkg::OP_PICK;
                    state_next = S_SW_RD1;
                end
            end
            S_SW_RD1:
            begin
                op         = spq_pkg::OP_SW_RD1;
                state_next = S_SW_RD2;
            end
            S_SW_RD2:
            begin
                op         = spq_pkg::OP_SW_RD2;
                state_next = S_SW_WR1;
            end
            S_SW_WR1:
            begin
                op         = spq_pkg::OP_SW_WR1;
                state_next = S_SW_WR2;
            end
            S_SW_WR2:
            begin
                op         = spq_pkg::OP_SW_WR2;
                state_next = S_FY_RNG;
            end
            S_RF_RD:
            begin
                if (sts.copy_done)
                begin
                    op         = spq_pkg::OP_SHUF_FIN;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = spq_pkg::OP_RF_RD;
                    state_next = S_RF_CMP;
                end
            end
            S_RF_CMP:
            begin
                op         = spq_pkg::OP_RF_CMP;
                state_next = sts.match ? S_SHUF_FIN : S_RF_RD;
            end
            S_SHUF_FIN:
            begin
                op         = spq_pkg::OP_SHUF_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                op = spq_pkg::OP_WAIT;
                if (sts.out_free)
                begin
                    op         = spq_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> ((state_reg == S_WRAP) || (state_reg == S_FY_WAIT)))
        else $error("remainder finished outside a wait state");
    a_dec_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        (op == spq_pkg::OP_LOAD) |=> (state_reg == S_DEC))
        else $error("accepted word not decoded");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/shuffle_play_queue.sv =====
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    req_type, track_id, position, to_front, steps, target_index
// out_ch    out  valid/ready    status, result_index, track_out, entry_count,
//                               current_index, shuffled, started, generation
// cfg       in   cfg_we         cfg_wdata = play mode (0 none, 1 wrap all, 2 hold one)
//
// One request word at a time; each gives one result word.
// Next/peek outside the queue wrap through the remainder unit in wrap-all mode.
// insert shifts later entries up; remove shifts the entries after the removed one down.
// shuffle on: copy, per entry LCG, remainder and swap, then refind of the current track.
// Reset (async, low) clears control; the order memories need no clearing pass.
// A finished word waits in the output register; the next request is taken meanwhile.
module shuffle_play_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    spq_in_if.sink                         in_ch,
    spq_out_if.source                      out_ch,
    input  wire logic                      cfg_we,
    input  wire logic [spq_pkg::RPT_W-1:0] cfg_wdata
);

    spq_pkg::cmd_t             cmd;
    spq_pkg::sts_t             sts;
    logic                      div_start;
    logic [spq_pkg::RNG_W-1:0] div_dividend;
    logic [spq_pkg::LEN_W-1:0] div_divisor;
    logic                      div_done;
    logic [spq_pkg::LEN_W-1:0] div_rem;

    // sequencer
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // queue storage, registers and result word
    spq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_req       (in_ch.req_type),
        .in_id        (in_ch.track_id),
        .in_pos       (in_ch.position),
        .in_front     (in_ch.to_front),
        .in_steps     (in_ch.steps),
        .in_tgt       (in_ch.target_index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_status   (out_ch.status),
        .out_rindex   (out_ch.result_index),
        .out_track    (out_ch.track_out),
        .out_count    (out_ch.entry_count),
        .out_cur      (out_ch.current_index),
        .out_shuf     (out_ch.shuffled),
        .out_started  (out_ch.started),
        .out_gen      (out_ch.generation),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_rem      (div_rem)
    );

    // shared remainder: wrap of current+steps and the shuffle pick
    spq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

endmodule

`default_nettype wire
